// ----- design/lsa_pkg.sv -----
// Shared types, codes and constants of the latency statistics accumulator.
`default_nettype none
package lsa_pkg;

  localparam int KINDS   = 5;
  localparam int PAIRS   = 5;
  localparam int RECORDS = KINDS * PAIRS;
  localparam int ADDR_W  = $clog2(RECORDS);

  localparam logic [0:0] OP_RECORD = 1'b0;
  localparam logic [0:0] OP_READ   = 1'b1;

  localparam logic [2:0] KIND_BOOK       = 3'd0;
  localparam logic [2:0] KIND_TRADE      = 3'd1;
  localparam logic [2:0] KIND_INSTRUMENT = 3'd3;

  localparam logic [2:0] PAIR_EXCH_PARSER   = 3'd0;
  localparam logic [2:0] PAIR_PARSER_SERVER = 3'd1;
  localparam logic [2:0] PAIR_SERVER_CUR    = 3'd2;
  localparam logic [2:0] PAIR_PARSER_CUR    = 3'd3;
  localparam logic [2:0] PAIR_EXCH_CUR      = 3'd4;

  localparam logic [63:0] MAX64S = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN64S = 64'h8000_0000_0000_0000;
  localparam logic [62:0] MAX63  = 63'h7FFF_FFFF_FFFF_FFFF;

  localparam int          SQ_DIVISOR = 1000000;
  localparam int          REM_W      = 20;
  localparam logic [REM_W:0] DIVISOR_W = (REM_W + 1)'(SQ_DIVISOR);

  localparam int HALF_W    = 21;
  localparam int PROD_W    = 2 * HALF_W;
  localparam int DIVD_W    = 88;
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = DIVD_W / DIV_BITS;
  localparam int MUL_STEPS = 3;

  typedef struct packed {
    logic [63:0] rmin;
    logic [63:0] rmax;
    logic [63:0] rsum;
    logic [62:0] rsq;
    logic [63:0] rcount;
  } record_t;

  localparam int REC_W = $bits(record_t);

  localparam record_t RESET_RECORD = '{
    rmin:   MAX64S,
    rmax:   MIN64S,
    rsum:   64'd0,
    rsq:    63'd0,
    rcount: 64'd0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAIR,
    ST_WAIT,
    ST_READ,
    ST_RESP
  } seq_state_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_MUL,
    SQ_DIV,
    SQ_DONE
  } sq_state_t;

endpackage
`default_nettype wire

// ----- design/lsa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module lsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- design/lsa_square_unit.sv -----
// Multicycle unit: floor(mag^2 / 1000000), saturated to the 63-bit maximum.
`default_nettype none
module lsa_square_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [62:0] mag,
  output logic             done,
  output logic      [62:0] term
);

  localparam int HW = lsa_pkg::HALF_W;
  localparam int PW = lsa_pkg::PROD_W;
  localparam int DW = lsa_pkg::DIVD_W;
  localparam int DB = lsa_pkg::DIV_BITS;
  localparam int RW = lsa_pkg::REM_W;

  lsa_pkg::sq_state_t state, state_next;
  logic [3:0]    step;
  logic [HW-1:0] mag_hi;
  logic [HW-1:0] mag_lo;
  logic          sat;
  logic [DW-1:0] acc;
  logic [RW-1:0] rem;

  logic [HW-1:0] op_a;
  logic [HW-1:0] op_b;
  logic [PW-1:0] prod;
  logic [DW-1:0] addend;
  logic [DW-1:0] div_acc_next;
  logic [RW-1:0] div_rem_next;

  always_comb begin
    case (step)
      4'd0: begin
        op_a = mag_hi;
        op_b = mag_hi;
      end
      4'd1: begin
        op_a = mag_hi;
        op_b = mag_lo;
      end
      default: begin
        op_a = mag_lo;
        op_b = mag_lo;
      end
    endcase
    prod = op_a * op_b;
    case (step)
      4'd0: begin
        addend = DW'(prod) << (2 * HW);
      end
      4'd1: begin
        addend = DW'(prod) << (HW + 1);
      end
      default: begin
        addend = DW'(prod);
      end
    endcase
  end

  always_comb begin
    logic [RW:0]   trial;
    logic [RW-1:0] r;
    logic [DB-1:0] qbits;
    r = rem;
    qbits = '0;
    for (int i = 0; i < DB; i++) begin
      trial = {r, acc[DW-1-i]};
      if (trial >= lsa_pkg::DIVISOR_W) begin
        trial = trial - lsa_pkg::DIVISOR_W;
        qbits[DB-1-i] = 1'b1;
      end
      r = trial[RW-1:0];
    end
    div_rem_next = r;
    div_acc_next = {acc[DW-DB-1:0], qbits};
  end

  always_comb begin
    state_next = state;
    case (state)
      lsa_pkg::SQ_IDLE: begin
        if (start) begin
          state_next = lsa_pkg::SQ_MUL;
        end
      end
      lsa_pkg::SQ_MUL: begin
        if (step == 4'(lsa_pkg::MUL_STEPS - 1)) begin
          state_next = lsa_pkg::SQ_DIV;
        end
      end
      lsa_pkg::SQ_DIV: begin
        if (step == 4'(lsa_pkg::DIV_STEPS - 1)) begin
          state_next = lsa_pkg::SQ_DONE;
        end
      end
      lsa_pkg::SQ_DONE: begin
        state_next = lsa_pkg::SQ_IDLE;
      end
      default: begin
        state_next = lsa_pkg::SQ_IDLE;
      end
    endcase
  end

  always_comb begin
    done = (state == lsa_pkg::SQ_DONE);
    term = (sat || (acc[DW-1:63] != '0)) ? lsa_pkg::MAX63 : acc[62:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsa_pkg::SQ_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      case (state)
        lsa_pkg::SQ_IDLE: begin
          step <= '0;
        end
        lsa_pkg::SQ_MUL: begin
          step <= (step == 4'(lsa_pkg::MUL_STEPS - 1)) ? 4'd0 : step + 4'd1;
        end
        lsa_pkg::SQ_DIV: begin
          step <= step + 4'd1;
        end
        default: begin
          step <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      lsa_pkg::SQ_IDLE: begin
        if (start) begin
          mag_hi <= mag[2*HW-1:HW];
          mag_lo <= mag[HW-1:0];
          sat    <= (mag[62:2*HW] != '0);
          acc    <= '0;
          rem    <= '0;
        end
      end
      lsa_pkg::SQ_MUL: begin
        acc <= acc + addend;
      end
      lsa_pkg::SQ_DIV: begin
        acc <= div_acc_next;
        rem <= div_rem_next;
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- design/lsa_update.sv -----
// Record merge: fold one delta and its square term into a statistics record.
`default_nettype none
module lsa_update (
  input  wire lsa_pkg::record_t old_rec,
  input  wire logic [63:0]      delta,
  input  wire logic [62:0]      term,
  output lsa_pkg::record_t      new_rec
);

  logic [63:0] sum_raw;
  logic        sum_ovf;
  logic [62:0] sq_room;

  always_comb begin
    sum_raw = old_rec.rsum + delta;
    sum_ovf = (old_rec.rsum[63] == delta[63]) && (sum_raw[63] != old_rec.rsum[63]);
    sq_room = lsa_pkg::MAX63 - term;

    new_rec.rmin = ($signed(delta) < $signed(old_rec.rmin)) ? delta : old_rec.rmin;
    new_rec.rmax = ($signed(old_rec.rmax) < $signed(delta)) ? delta : old_rec.rmax;
    if (sum_ovf) begin
      new_rec.rsum = old_rec.rsum[63] ? lsa_pkg::MIN64S : lsa_pkg::MAX64S;
    end else begin
      new_rec.rsum = sum_raw;
    end
    new_rec.rsq = (old_rec.rsq > sq_room) ? lsa_pkg::MAX63 : old_rec.rsq + term;
    new_rec.rcount = old_rec.rcount + 64'd1;
  end

endmodule
`default_nettype wire

// ----- design/latency_statistics_accumulator_core.sv -----
// Top level of the latency statistics accumulator: sequencer, record memory, square unit.
`default_nettype none
// Keeps min, max, saturating sum, saturating sum of delta^2/1e6 and count for
// 25 records (5 message kinds x 5 timestamp pairs) in one 319-bit x 25 RAM.
// One item is worked at a time. A read item reads its record from the RAM,
// loads the result into the output register, and frees the input once that
// register has taken it, waiting while the output register is stalled; a
// record item skips inactive pairs and waits on the square unit for each
// updated pair (an unknown kind leaves the input free). The square unit has
// one 21x21 multiplier over three passes, then divides by one million at
// eight quotient bits per cycle. Each updated pair does one RAM read and one
// write back; valid bits give never-written records their reset value.
module latency_statistics_accumulator_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write_enable,
  input  wire logic               cfg_write_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               opcode,
  input  wire logic        [2:0]  message_kind,
  input  wire logic        [62:0] exchange_time,
  input  wire logic        [62:0] parser_time,
  input  wire logic        [62:0] server_time,
  input  wire logic        [62:0] current_time,
  input  wire logic        [2:0]  read_kind,
  input  wire logic        [2:0]  read_pair,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [63:0] min_delta,
  output logic signed      [63:0] max_delta,
  output logic signed      [63:0] delta_sum,
  output logic             [62:0] square_sum,
  output logic             [63:0] sample_count,
  output logic             [63:0] message_count
);

  localparam int AW = lsa_pkg::ADDR_W;

  lsa_pkg::seq_state_t state, state_next;
  logic                brief_mode;
  logic [63:0]         total_messages;
  logic [2:0]          kind;
  logic [62:0]         et;
  logic [62:0]         pt;
  logic [62:0]         st;
  logic [62:0]         ct;
  logic [2:0]          rk;
  logic [2:0]          rp;
  logic [2:0]          pair;
  logic [63:0]         delta;
  logic [lsa_pkg::RECORDS-1:0] valid;

  logic             accept;
  logic [62:0]      from_t;
  logic [62:0]      to_t;
  logic             pair_active;
  logic             pair_last;
  logic [AW-1:0]    rec_idx;
  logic             read_ok;
  logic [AW-1:0]    read_idx;
  logic [63:0]      delta_comb;
  logic [63:0]      delta_neg;
  logic [62:0]      mag;
  logic             ram_rd_en;
  logic [AW-1:0]    ram_rd_addr;
  logic             ram_wr_en;
  logic             sq_start;
  logic             sq_done;
  logic [62:0]      sq_term;
  logic             load_out;
  lsa_pkg::record_t ram_rd_data;
  lsa_pkg::record_t old_rec;
  lsa_pkg::record_t new_rec;
  lsa_pkg::record_t resp_rec;

  lsa_ram #(
    .WIDTH (lsa_pkg::REC_W),
    .DEPTH (lsa_pkg::RECORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (rec_idx),
    .wr_data (new_rec),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  lsa_square_unit u_square (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .mag   (mag),
    .done  (sq_done),
    .term  (sq_term)
  );

  lsa_update u_update (
    .old_rec (old_rec),
    .delta   (delta),
    .term    (sq_term),
    .new_rec (new_rec)
  );

  always_comb begin
    case (pair)
      lsa_pkg::PAIR_EXCH_PARSER: begin
        from_t = et;
        to_t   = pt;
      end
      lsa_pkg::PAIR_PARSER_SERVER: begin
        from_t = pt;
        to_t   = st;
      end
      lsa_pkg::PAIR_SERVER_CUR: begin
        from_t = st;
        to_t   = ct;
      end
      lsa_pkg::PAIR_PARSER_CUR: begin
        from_t = pt;
        to_t   = ct;
      end
      lsa_pkg::PAIR_EXCH_CUR: begin
        from_t = et;
        to_t   = ct;
      end
      default: begin
        from_t = '0;
        to_t   = '0;
      end
    endcase

    pair_active = (from_t != '0) && (to_t != '0) &&
                  (!brief_mode || ((pair == lsa_pkg::PAIR_EXCH_PARSER) &&
                                   (kind inside {lsa_pkg::KIND_BOOK, lsa_pkg::KIND_TRADE})));
    pair_last   = brief_mode || (pair == 3'(lsa_pkg::PAIRS - 1));
    rec_idx     = AW'(kind * lsa_pkg::PAIRS + pair);

    read_ok  = (rk < 3'(lsa_pkg::KINDS)) && (rp < 3'(lsa_pkg::PAIRS));
    read_idx = read_ok ? AW'(rk * lsa_pkg::PAIRS + rp) : '0;

    delta_comb = {1'b0, to_t} - {1'b0, from_t};
    delta_neg  = 64'd0 - delta_comb;
    mag        = delta_comb[63] ? delta_neg[62:0] : delta_comb[62:0];

    old_rec  = valid[rec_idx] ? ram_rd_data : lsa_pkg::RESET_RECORD;
    resp_rec = (read_ok && valid[read_idx]) ? ram_rd_data : lsa_pkg::RESET_RECORD;
  end

  always_comb begin
    state_next = state;
    case (state)
      lsa_pkg::ST_IDLE: begin
        if (accept) begin
          if (opcode == lsa_pkg::OP_READ) begin
            state_next = lsa_pkg::ST_READ;
          end else if (message_kind < 3'(lsa_pkg::KINDS)) begin
            state_next = lsa_pkg::ST_PAIR;
          end
        end
      end
      lsa_pkg::ST_PAIR: begin
        if (pair_active) begin
          state_next = lsa_pkg::ST_WAIT;
        end else if (pair_last) begin
          state_next = lsa_pkg::ST_IDLE;
        end
      end
      lsa_pkg::ST_WAIT: begin
        if (sq_done) begin
          state_next = pair_last ? lsa_pkg::ST_IDLE : lsa_pkg::ST_PAIR;
        end
      end
      lsa_pkg::ST_READ: begin
        state_next = lsa_pkg::ST_RESP;
      end
      lsa_pkg::ST_RESP: begin
        if (load_out) begin
          state_next = lsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall    = (state != lsa_pkg::ST_IDLE);
    accept      = in_valid && !in_stall;
    sq_start    = (state == lsa_pkg::ST_PAIR) && pair_active;
    ram_rd_en   = sq_start || (state == lsa_pkg::ST_READ);
    ram_rd_addr = (state == lsa_pkg::ST_READ) ? read_idx : rec_idx;
    ram_wr_en   = (state == lsa_pkg::ST_WAIT) && sq_done;
    load_out    = (state == lsa_pkg::ST_RESP) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= lsa_pkg::ST_IDLE;
      brief_mode     <= 1'b0;
      total_messages <= '0;
      valid          <= '0;
      out_valid      <= 1'b0;
      pair           <= '0;
    end else begin
      state <= state_next;
      if (cfg_write_enable) begin
        brief_mode <= cfg_write_data;
      end
      if (accept) begin
        pair <= '0;
        if (opcode == lsa_pkg::OP_RECORD) begin
          total_messages <= total_messages + 64'd1;
        end
      end
      if ((state == lsa_pkg::ST_PAIR) && !pair_active && !pair_last) begin
        pair <= pair + 3'd1;
      end
      if (ram_wr_en) begin
        valid[rec_idx] <= 1'b1;
        if (!pair_last) begin
          pair <= pair + 3'd1;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind <= message_kind;
      et   <= (message_kind == lsa_pkg::KIND_INSTRUMENT) ? 63'd0 : exchange_time;
      pt   <= parser_time;
      st   <= server_time;
      ct   <= current_time;
      rk   <= read_kind;
      rp   <= read_pair;
    end
    if (sq_start) begin
      delta <= delta_comb;
    end
    if (load_out) begin
      min_delta     <= resp_rec.rmin;
      max_delta     <= resp_rec.rmax;
      delta_sum     <= resp_rec.rsum;
      square_sum    <= resp_rec.rsq;
      sample_count  <= resp_rec.rcount;
      message_count <= total_messages;
    end
  end

endmodule
`default_nettype wire
